>>> hdl/htfd_pkg.sv
// htfd_pkg: shared types, constants and the crc-8 helper for the
// humidity/temperature frame decoder
// no dependencies
`default_nettype none

package htfd_pkg;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ACK_ERR = 2'd1,
      STATUS_CRC_ERR = 2'd2
   } status_type;

   localparam logic [7:0]  CRC_POLY   = 8'h31;
   localparam logic [7:0]  CRC_INIT   = 8'hFF;
   localparam logic [10:0] TEMP_SPAN  = 11'd1750;
   localparam logic [9:0]  HUMI_SPAN  = 10'd1000;
   localparam logic [11:0] TEMP_OFFSET = 12'd450;

   // completed frame, waiting for scaling
   typedef struct packed {
      status_type  status;
      logic [15:0] temp_raw;
      logic [15:0] humi_raw;
   } raw_beat_type;

   // crc-8, msb first, one byte
   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hdl/htfd_frame.sv
// htfd_frame: byte sequencing and crc check of one measurement frame
// depends on htfd_pkg
`default_nettype none

module htfd_frame (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_kind,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic                  raw_ready,
   output logic                       raw_valid,
   output htfd_pkg::raw_beat_type     raw_beat
);
   import htfd_pkg::*;

   localparam logic [2:0] POS_TEMP_MSB = 3'd0;
   localparam logic [2:0] POS_TEMP_LSB = 3'd1;
   localparam logic [2:0] POS_HUMI_MSB = 3'd3;
   localparam logic [2:0] POS_HUMI_LSB = 3'd4;
   localparam logic [2:0] POS_LAST     = 3'd5;

   logic [2:0]   pos_ff, pos_in;
   logic [7:0]   crc_ff, crc_in;
   logic [15:0]  temp_raw_ff, temp_raw_in;
   logic [15:0]  humi_raw_ff, humi_raw_in;
   logic         crc_failed_ff, crc_failed_in;
   logic         raw_valid_ff, raw_valid_in;
   raw_beat_type raw_beat_ff, raw_beat_in;

   logic         accept;
   logic         emit;
   logic [7:0]   crc_feed_out;

   assign req_stall = raw_valid_ff && !raw_ready;
   assign accept    = req_valid && !req_stall;

   // first byte of a word starts from the init value
   assign crc_feed_out = crc_feed(((pos_ff == POS_TEMP_MSB) || (pos_ff == POS_HUMI_MSB)) ?
                                  CRC_INIT : crc_ff, req_rx_byte);

   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      temp_raw_in   = temp_raw_ff;
      humi_raw_in   = humi_raw_ff;
      crc_failed_in = crc_failed_ff;
      emit          = 1'b0;
      raw_beat_in   = raw_beat_ff;

      if (accept) begin
         if (req_kind) begin
            emit                 = 1'b1;
            raw_beat_in.status   = STATUS_ACK_ERR;
            raw_beat_in.temp_raw = '0;
            raw_beat_in.humi_raw = '0;
            pos_in               = POS_TEMP_MSB;
            crc_in               = CRC_INIT;
            temp_raw_in          = '0;
            humi_raw_in          = '0;
            crc_failed_in        = 1'b0;
         end else begin
            case (pos_ff)
               POS_TEMP_MSB: begin
                  crc_in      = crc_feed_out;
                  temp_raw_in = {req_rx_byte, 8'h00};
               end
               POS_HUMI_MSB: begin
                  crc_in      = crc_feed_out;
                  humi_raw_in = {req_rx_byte, 8'h00};
               end
               POS_TEMP_LSB: begin
                  crc_in      = crc_feed_out;
                  temp_raw_in = {temp_raw_ff[15:8], req_rx_byte};
               end
               POS_HUMI_LSB: begin
                  crc_in      = crc_feed_out;
                  humi_raw_in = {humi_raw_ff[15:8], req_rx_byte};
               end
               default: begin
                  // checksum byte
                  if (req_rx_byte != crc_ff) begin
                     crc_failed_in = 1'b1;
                  end
                  crc_in = CRC_INIT;
               end
            endcase

            if (pos_ff < POS_LAST) begin
               pos_in = pos_ff + 3'd1;
            end else begin
               emit                 = 1'b1;
               raw_beat_in.status   = crc_failed_in ? STATUS_CRC_ERR : STATUS_OK;
               raw_beat_in.temp_raw = temp_raw_in;
               raw_beat_in.humi_raw = humi_raw_in;
               pos_in               = POS_TEMP_MSB;
               crc_in               = CRC_INIT;
               temp_raw_in          = '0;
               humi_raw_in          = '0;
               crc_failed_in        = 1'b0;
            end
         end
      end

      if (emit) begin
         raw_valid_in = 1'b1;
      end else if (raw_ready) begin
         raw_valid_in = 1'b0;
      end else begin
         raw_valid_in = raw_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_TEMP_MSB;
         crc_ff        <= CRC_INIT;
         temp_raw_ff   <= '0;
         humi_raw_ff   <= '0;
         crc_failed_ff <= 1'b0;
         raw_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         temp_raw_ff   <= temp_raw_in;
         humi_raw_ff   <= humi_raw_in;
         crc_failed_ff <= crc_failed_in;
         raw_valid_ff  <= raw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_beat_ff <= raw_beat_in;
   end

   assign raw_valid = raw_valid_ff;
   assign raw_beat  = raw_beat_ff;

endmodule

`default_nettype wire

>>> hdl/htfd_scale.sv
// htfd_scale: converts raw words to tenths of a degree and of a percent,
// holds the result register; depends on htfd_pkg
`default_nettype none

module htfd_scale (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  raw_valid,
   output logic                       raw_ready,
   input  wire htfd_pkg::raw_beat_type raw_beat,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic signed [11:0]         rsp_temperature,
   output logic [9:0]                 rsp_humidity
);
   import htfd_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [11:0] temp_ff, temp_in;
   logic [9:0]  humi_ff, humi_in;

   logic [27:0] temp_prod;
   logic [27:0] humi_prod;
   logic [27:0] temp_sum;
   logic [27:0] humi_sum;
   logic [10:0] temp_quot;
   logic [9:0]  humi_quot;

   assign raw_ready = !out_valid_ff || !rsp_stall;

   // x / 65535 as (x + (x >> 16) + 1) >> 16, exact while the quotient fits 16 bits
   assign temp_prod = 28'(TEMP_SPAN) * 28'(raw_beat.temp_raw);
   assign humi_prod = 28'(HUMI_SPAN) * 28'(raw_beat.humi_raw);
   assign temp_sum  = temp_prod + {16'h0000, temp_prod[27:16]} + 28'd1;
   assign humi_sum  = humi_prod + {16'h0000, humi_prod[27:16]} + 28'd1;
   assign temp_quot = temp_sum[26:16];
   assign humi_quot = humi_sum[25:16];

   always_comb begin
      out_valid_in = out_valid_ff;
      status_in    = status_ff;
      temp_in      = temp_ff;
      humi_in      = humi_ff;
      if (raw_ready) begin
         out_valid_in = raw_valid;
         status_in    = raw_beat.status;
         if (raw_beat.status == STATUS_OK) begin
            temp_in = {1'b0, temp_quot} - TEMP_OFFSET;
            humi_in = humi_quot;
         end else begin
            temp_in = '0;
            humi_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      temp_ff   <= temp_in;
      humi_ff   <= humi_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_temperature = temp_ff;
   assign rsp_humidity    = humi_ff;

endmodule

`default_nettype wire

>>> hdl/humidity_temp_frame_decoder.sv
// Measurement frame decoder: takes the six bytes of a temperature/humidity frame one
// beat at a time (temperature msb, lsb, crc, humidity msb, lsb, crc), checks each word
// with crc-8 (poly 0x31, init 0xff) and after the sixth byte returns one result beat
// with status, temperature in 0.1 degree and humidity in 0.1 percent. An abort beat
// (req_kind high) drops the frame and returns an acknowledge error at once. One input
// beat is taken every cycle while req_stall is low; a result passes through one
// register for the frame decode and one for the scaling multiply. The input stalls
// only while both the decoded-frame register and the result register hold beats and
// rsp_stall is high.
// depends on htfd_pkg, htfd_frame, htfd_scale
`default_nettype none

module humidity_temp_frame_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [11:0]      rsp_temperature,
   output logic [9:0]              rsp_humidity
);
   import htfd_pkg::*;

   logic         raw_valid;
   logic         raw_ready;
   raw_beat_type raw_beat;

   htfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .raw_ready   (raw_ready),
      .raw_valid   (raw_valid),
      .raw_beat    (raw_beat)
   );

   htfd_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .raw_valid       (raw_valid),
      .raw_ready       (raw_ready),
      .raw_beat        (raw_beat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_temperature (rsp_temperature),
      .rsp_humidity    (rsp_humidity)
   );

endmodule

`default_nettype wire

>>> hdl/htfd_checker.sv
// htfd_assertions: port-level assertions for the frame decoder, bound to the top level
// depends on htfd_pkg
`default_nettype none

module htfd_assertions (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [1:0]         rsp_status,
   input wire logic signed [11:0] rsp_temperature,
   input wire logic [9:0]         rsp_humidity
);
   import htfd_pkg::*;

   // error beats carry no measurement
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_temperature == 12'sd0) &&
                                                 (rsp_humidity == 10'd0))
      else $error("error beat with nonzero measurement");

   // scaled values stay within sensor span
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) |-> (rsp_humidity <= 10'd1000) &&
         (rsp_temperature >= -12'sd450) && (rsp_temperature <= 12'sd1300))
      else $error("measurement out of range");

   // input stalls only when a result is backed up
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free result path");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_temperature) && $stable(rsp_humidity))
      else $error("stalled result beat changed");

endmodule

bind humidity_temp_frame_decoder htfd_assertions u_htfd_assertions (.*);

`default_nettype wire

>>> tb/htfd_checker.sv
// htfd_checker: watches the byte and result channels of the frame decoder,
// predicts each result from the accepted bytes and compares it field by field
// depends on htfd_pkg
`timescale 1ns / 100ps

module htfd_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic              req_kind,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [1:0]        rsp_status,
   input  wire logic signed [11:0] rsp_temperature,
   input  wire logic [9:0]        rsp_humidity,
   output int                     fail_count,
   output int                     pending
);
   import htfd_pkg::*;

   typedef struct packed {
      status_type         status;
      logic signed [11:0] temperature;
      logic [9:0]         humidity;
   } reading_type;

   reading_type pending_readings[$];

   // decoder state as the frame bytes arrive
   logic [2:0]  frame_pos;
   logic [7:0]  word_crc;
   logic [15:0] temp_word;
   logic [15:0] humi_word;
   logic        crc_bad;

   // serial form of the crc, one data bit per shift
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         if (acc[7] ^ data[i]) begin
            acc = {acc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

   task automatic clear_frame();
      frame_pos = 3'd0;
      word_crc  = CRC_INIT;
      temp_word = 16'h0000;
      humi_word = 16'h0000;
      crc_bad   = 1'b0;
   endtask

   task automatic absorb_beat(input logic kind, input logic [7:0] data);
      reading_type     r;
      int unsigned     t_scaled;
      int unsigned     h_scaled;
      r.status      = STATUS_ACK_ERR;
      r.temperature = '0;
      r.humidity    = '0;
      // abort drops the frame wherever it stands
      if (kind) begin
         pending_readings.push_back(r);
         clear_frame();
         return;
      end
      case (frame_pos)
         3'd0, 3'd3: begin
            word_crc = crc_step(CRC_INIT, data);
            if (frame_pos == 3'd0) temp_word = {data, 8'h00};
            else humi_word = {data, 8'h00};
         end
         3'd1, 3'd4: begin
            word_crc = crc_step(word_crc, data);
            if (frame_pos == 3'd1) temp_word[7:0] = data;
            else humi_word[7:0] = data;
         end
         default: begin
            if (data != word_crc) crc_bad = 1'b1;
            word_crc = CRC_INIT;
         end
      endcase
      if (frame_pos != 3'd5) begin
         frame_pos = frame_pos + 3'd1;
         return;
      end
      if (crc_bad) begin
         r.status = STATUS_CRC_ERR;
      end else begin
         t_scaled      = (32'(TEMP_SPAN) * 32'(temp_word)) / 32'd65535;
         h_scaled      = (32'(HUMI_SPAN) * 32'(humi_word)) / 32'd65535;
         r.status      = STATUS_OK;
         r.temperature = t_scaled[11:0] - TEMP_OFFSET;
         r.humidity    = h_scaled[9:0];
      end
      pending_readings.push_back(r);
      clear_frame();
   endtask

   task automatic check_reading();
      reading_type want;
      if (pending_readings.size() == 0) begin
         $error("result beat with nothing outstanding: status %0d temperature %0d humidity %0d",
                rsp_status, rsp_temperature, rsp_humidity);
         fail_count++;
         return;
      end
      want = pending_readings.pop_front();
      if (rsp_status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, rsp_status);
         fail_count++;
      end
      if (rsp_temperature !== want.temperature) begin
         $error("temperature: expected %0d, got %0d", want.temperature, rsp_temperature);
         fail_count++;
      end
      if (rsp_humidity !== want.humidity) begin
         $error("humidity: expected %0d, got %0d", want.humidity, rsp_humidity);
         fail_count++;
      end
   endtask

   // results leave only after their last byte has been registered, so compare first
   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         pending_readings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_reading();
         if (req_valid && !req_stall) absorb_beat(req_kind, req_rx_byte);
      end
      pending = pending_readings.size();
   end

endmodule

>>> tb/tb.sv
// tb: top of the frame decoder testbench; drives frame bytes and result stalls,
// instantiates the decoder beside htfd_checker and prints the verdict
// depends on htfd_pkg, humidity_temp_frame_decoder, htfd_checker
`timescale 1ns / 100ps

module tb;
   import htfd_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_kind;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic signed [11:0] rsp_temperature;
   logic [9:0]         rsp_humidity;

   int   fail_count;
   int   pending;
   int   beats_sent;
   logic burst;
   logic random_phase;

   humidity_temp_frame_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_temperature (rsp_temperature),
      .rsp_humidity    (rsp_humidity)
   );

   htfd_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_temperature (rsp_temperature),
      .rsp_humidity    (rsp_humidity),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // checksum byte that seals a 16-bit word, msb first
   function automatic logic [7:0] sealed_crc(input logic [15:0] word);
      logic [7:0] acc;
      acc = CRC_INIT;
      for (int i = 15; i >= 0; i--) begin
         if (acc[7] ^ word[i]) begin
            acc = (acc << 1) ^ CRC_POLY;
         end else begin
            acc = acc << 1;
         end
      end
      return acc;
   endfunction

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 255));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // called and returning at a falling edge
   task automatic send_beat(input logic kind, input logic [7:0] data);
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_rx_byte <= data;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_frame(input logic [15:0] temp_word, input logic [15:0] humi_word,
                             input logic [7:0] temp_spoil, input logic [7:0] humi_spoil);
      send_beat(1'b0, temp_word[15:8]);
      send_beat(1'b0, temp_word[7:0]);
      send_beat(1'b0, sealed_crc(temp_word) ^ temp_spoil);
      send_beat(1'b0, humi_word[15:8]);
      send_beat(1'b0, humi_word[7:0]);
      send_beat(1'b0, sealed_crc(humi_word) ^ humi_spoil);
   endtask

   // receiver: random stalls, plus one long hold once the random part starts
   initial begin : receiver
      int r;
      int hold;
      logic squeezed;
      rsp_stall = 1'b0;
      squeezed  = 1'b0;
      forever begin
         @(negedge clock);
         if (random_phase && !squeezed) begin
            squeezed  = 1'b1;
            rsp_stall <= 1'b1;
            hold = 0;
            while (hold < 300) begin
               @(negedge clock);
               hold++;
            end
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 12)) @(negedge clock);
            end else if (r < 95) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 3)) @(negedge clock);
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(10, 40)) @(negedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int       pick;
      int       n;
      int       sel;
      logic [7:0] t_spoil;
      logic [7:0] h_spoil;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_kind     = 1'b0;
      req_rx_byte  = 8'h00;
      burst        = 1'b0;
      random_phase = 1'b0;
      beats_sent   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // abort with no frame open, rx_byte ignored
      send_beat(1'b1, 8'hFF);
      // coldest/driest and hottest/wettest readings
      send_frame(16'h0000, 16'h0000, 8'h00, 8'h00);
      send_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00);
      // both words fail their checksum
      send_frame(16'h6666, 16'h8000, 8'h01, 8'h80);
      // abort in the middle of a frame
      send_beat(1'b0, 8'hAA);
      send_beat(1'b0, 8'h55);
      send_beat(1'b0, sealed_crc(16'hAA55));
      send_beat(1'b1, 8'h00);

      random_phase = 1'b1;
      while (beats_sent < 1000) begin
         pick  = $urandom_range(0, 99);
         burst = ($urandom_range(0, 3) == 0);
         if (pick < 70) begin
            send_frame(rand_word(), rand_word(), 8'h00, 8'h00);
         end else if (pick < 82) begin
            // spoil temperature, humidity or both checksums
            sel     = $urandom_range(1, 3);
            t_spoil = sel[0] ? 8'($urandom_range(1, 255)) : 8'h00;
            h_spoil = sel[1] ? 8'($urandom_range(1, 255)) : 8'h00;
            send_frame(rand_word(), rand_word(), t_spoil, h_spoil);
         end else if (pick < 92) begin
            n = $urandom_range(0, 5);
            repeat (n) send_beat(1'b0, 8'($urandom_range(0, 255)));
            send_beat(1'b1, 8'($urandom_range(0, 255)));
         end else begin
            send_beat(1'b1, 8'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // the slowest run ends well before this limit
   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
